[rtl/core/sbp_pkg.sv]
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types, codes and helpers for the static branch predictor with BTB.
// ----------------------------------------------------------------------------
package sbp_pkg;

	localparam logic [6:0] OPCODE_MASK   = 7'h7f;
	localparam logic [6:0] OPCODE_BRANCH = 7'h63;
	localparam logic [2:0] FUNCT3_RSV_A  = 3'h2;
	localparam logic [2:0] FUNCT3_RSV_B  = 3'h3;
	localparam logic [31:0] PC_STEP      = 32'd4;

	// Status codes of a result.
	localparam logic [1:0] ST_VALID_BRANCH = 2'd0;
	localparam logic [1:0] ST_NOT_BRANCH   = 2'd1;
	localparam logic [1:0] ST_RSV_FUNCT3   = 2'd2;

	// Direction policies.
	localparam logic [1:0] MODE_NOT_TAKEN = 2'd0;
	localparam logic [1:0] MODE_TAKEN     = 2'd1;
	localparam logic [1:0] MODE_BTFN      = 2'd2;

	// Lookup kinds.
	localparam logic [1:0] LK_HIT        = 2'd0;
	localparam logic [1:0] LK_COLD_MISS  = 2'd1;
	localparam logic [1:0] LK_CONFLICT   = 2'd2;
	localparam logic [1:0] LK_DISABLED   = 2'd3;

	// Update kinds.
	localparam logic [1:0] UK_COLD_FILL  = 2'd0;
	localparam logic [1:0] UK_REFRESH    = 2'd1;
	localparam logic [1:0] UK_REPLACE    = 2'd2;
	localparam logic [1:0] UK_NONE       = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_DIRECTION_MODE = 2'd0;
	localparam logic [1:0] REG_BTB_ENABLE     = 2'd1;
	localparam logic [1:0] REG_BTB_INDEX_BITS = 2'd2;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	// Decoded view of one traced branch.
	typedef struct packed {
		logic [1:0]  status;
		logic        backward;
		logic [31:0] target;
		logic [31:0] seq;
	} dec_t;

	// One BTB entry as held in the memory.
	typedef struct packed {
		logic        valid;
		logic [31:0] pc;
		logic [31:0] target;
		logic        backward;
	} btb_slot_t;

	function automatic logic direction_of(input logic [1:0] mode, input logic backward);
		logic taken;
		case (mode)
			MODE_TAKEN: taken = 1'b1;
			MODE_BTFN:  taken = backward;
			default:    taken = 1'b0;
		endcase
		return taken;
	endfunction

endpackage

[rtl/core/static_branch_predictor_btb.sv]
// ----------------------------------------------------------------------------
// static_branch_predictor_btb
// Direct-mapped BTB with a static direction policy for traced branches.
// ----------------------------------------------------------------------------
// Usage
// The input channel (in_valid/in_ready) carries one traced branch per request:
// its pc, instruction word and real outcome. The output channel
// (out_valid/out_ready) returns exactly one result request for each of them.
// An accepted request waits in the lookup stage for its memory read, and its
// result is registered as it advances. The BTB sits in a synchronous memory:
// the entry is read as the request is accepted and written back as the
// request moves on to the result register, and a read of the entry being
// written is forwarded. With out_ready held high one request is taken in
// every cycle.
// The result register parts the two sides: a new request is taken while a
// result still waits. Clearing apart, in_ready drops only when both the
// result register and the lookup stage are full, until out_ready rises.
// After reset a clearing pass writes every built entry invalid, one entry a
// cycle, 2^floor(log2(BTB_SLOTS)) entries in all; in_ready stays low meanwhile.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant to arrive only while the block is idle.
// ----------------------------------------------------------------------------
module static_branch_predictor_btb #(
	parameter int BTB_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] branch_pc,
	input  logic [31:0] instruction_word,
	input  logic        branch_taken,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        predict_taken,
	output logic [31:0] predicted_next_pc,
	output logic [31:0] resolved_next_pc,
	output logic        dir_match,
	output logic        npc_match,
	output logic        ideal_dir_match,
	output logic        ideal_npc_match,
	output logic [1:0]  lookup_kind,
	output logic [1:0]  update_kind,
	output logic        target_mismatch
);

	// Index bits the memory is built for, and its depth.
	localparam int BUILT_BITS = $clog2(BTB_SLOTS + 1) - 1;
	localparam int IDX_W      = (BUILT_BITS < 1) ? 1 : BUILT_BITS;
	localparam int DEPTH      = 1 << BUILT_BITS;

	// Configuration registers.
	logic [1:0] direction_mode_q;
	logic       btb_enable_q;
	logic [1:0] btb_index_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_mode_q <= sbp_pkg::MODE_BTFN;
			btb_enable_q     <= 1'b1;
			btb_index_bits_q <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				sbp_pkg::REG_DIRECTION_MODE: direction_mode_q <= cfg_data;
				sbp_pkg::REG_BTB_ENABLE:     btb_enable_q     <= cfg_data[0];
				sbp_pkg::REG_BTB_INDEX_BITS: btb_index_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clearing sequencer.
	sbp_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             clr_last;
	logic             clearing;

	assign clr_last = (clr_cnt_q == IDX_W'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		clearing = 1'b0;
		case (state_q)
			sbp_pkg::ST_CLEAR: begin
				clearing = 1'b1;
				if (clr_last) begin
					state_d = sbp_pkg::ST_RUN;
				end
			end
			sbp_pkg::ST_RUN: begin
				clearing = 1'b0;
			end
			default: begin
				state_d = sbp_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing && !clr_last) begin
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
		end
	end

	// Decode of the incoming request.
	sbp_pkg::dec_t dec;

	sbp_decode u_decode (
		.branch_pc        (branch_pc),
		.instruction_word (instruction_word),
		.dec              (dec)
	);

	// The index width in use is limited to what the memory was built for.
	logic [3:0]       eff_bits;
	logic [IDX_W-1:0] idx_mask;
	logic [IDX_W-1:0] in_idx;

	always_comb begin
		if ({2'b00, btb_index_bits_q} > 4'(BUILT_BITS)) begin
			eff_bits = 4'(BUILT_BITS);
		end else begin
			eff_bits = {2'b00, btb_index_bits_q};
		end
		for (int k = 0; k < IDX_W; k++) begin
			idx_mask[k] = (k < int'(eff_bits));
		end
		in_idx = branch_pc[IDX_W+1:2] & idx_mask;
	end

	// Lookup stage: the request waits here for its memory read.
	logic                valid_s1;
	logic [31:0]         pc_s1;
	logic                taken_s1;
	sbp_pkg::dec_t       dec_s1;
	logic [IDX_W-1:0]    idx_s1;
	sbp_pkg::btb_slot_t  rd_entry_s1;
	logic                fwd_s1;
	sbp_pkg::btb_slot_t  fwd_entry_s1;

	logic out_valid_q;
	logic advance;
	logic accept;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !clearing && (!valid_s1 || advance);
	assign accept   = in_valid && in_ready;

	// Evaluation of the request in the lookup stage.
	sbp_pkg::btb_slot_t  entry;
	sbp_pkg::btb_slot_t  wr_entry;
	logic                item_we;
	logic                hit;
	logic                ideal_taken;
	logic [31:0]         ideal_next;
	logic [31:0]         resolved;
	logic                pred_taken;
	logic [31:0]         pred_next;
	logic [1:0]          lookup_d;
	logic [1:0]          update_d;
	logic                mismatch_d;
	logic                is_valid;

	always_comb begin
		entry       = fwd_s1 ? fwd_entry_s1 : rd_entry_s1;
		is_valid    = (dec_s1.status == sbp_pkg::ST_VALID_BRANCH);
		hit         = entry.valid && (entry.pc == pc_s1);
		ideal_taken = sbp_pkg::direction_of(direction_mode_q, dec_s1.backward);
		ideal_next  = ideal_taken ? dec_s1.target : dec_s1.seq;
		resolved    = taken_s1 ? dec_s1.target : dec_s1.seq;

		wr_entry.valid    = 1'b1;
		wr_entry.pc       = pc_s1;
		wr_entry.target   = dec_s1.target;
		wr_entry.backward = dec_s1.backward;

		item_we    = 1'b0;
		lookup_d   = sbp_pkg::LK_DISABLED;
		update_d   = sbp_pkg::UK_NONE;
		mismatch_d = 1'b0;
		pred_taken = ideal_taken;
		pred_next  = ideal_next;

		if (is_valid && btb_enable_q) begin
			item_we = 1'b1;
			if (hit) begin
				lookup_d   = sbp_pkg::LK_HIT;
				update_d   = sbp_pkg::UK_REFRESH;
				mismatch_d = (entry.target != dec_s1.target);
				pred_taken = sbp_pkg::direction_of(direction_mode_q, entry.backward);
				pred_next  = pred_taken ? entry.target : dec_s1.seq;
			end else begin
				lookup_d   = entry.valid ? sbp_pkg::LK_CONFLICT : sbp_pkg::LK_COLD_MISS;
				update_d   = entry.valid ? sbp_pkg::UK_REPLACE : sbp_pkg::UK_COLD_FILL;
				pred_taken = 1'b0;
				pred_next  = dec_s1.seq;
			end
		end
	end

	// BTB memory: one write port shared by the clearing pass and write-back,
	// one registered read port used as a request is accepted.
	sbp_pkg::btb_slot_t  btb_mem_q [DEPTH];
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	sbp_pkg::btb_slot_t  mem_wd;

	always_comb begin
		if (clearing) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = '0;
		end else begin
			mem_we = advance && item_we;
			mem_wa = idx_s1;
			mem_wd = wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			btb_mem_q[mem_wa] <= mem_wd;
		end
		if (accept) begin
			rd_entry_s1 <= btb_mem_q[in_idx];
		end
	end

	// Lookup stage registers. When the request ahead writes the entry that is
	// being read in the same cycle, the written value is kept and used instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= advance && item_we && (idx_s1 == in_idx);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pc_s1        <= branch_pc;
			taken_s1     <= branch_taken;
			dec_s1       <= dec;
			idx_s1       <= in_idx;
			fwd_entry_s1 <= wr_entry;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [1:0]  status_q;
	logic        predict_taken_q;
	logic [31:0] predicted_next_pc_q;
	logic [31:0] resolved_next_pc_q;
	logic        dir_match_q;
	logic        npc_match_q;
	logic        ideal_dir_match_q;
	logic        ideal_npc_match_q;
	logic [1:0]  lookup_kind_q;
	logic [1:0]  update_kind_q;
	logic        target_mismatch_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= dec_s1.status;
			if (is_valid) begin
				predict_taken_q     <= pred_taken;
				predicted_next_pc_q <= pred_next;
				resolved_next_pc_q  <= resolved;
				dir_match_q         <= (pred_taken == taken_s1);
				npc_match_q         <= (pred_next == resolved);
				ideal_dir_match_q   <= (ideal_taken == taken_s1);
				ideal_npc_match_q   <= (ideal_next == resolved);
				lookup_kind_q       <= lookup_d;
				update_kind_q       <= update_d;
				target_mismatch_q   <= mismatch_d;
			end else begin
				// A request that is not a usable branch reports its status and nothing else.
				predict_taken_q     <= 1'b0;
				predicted_next_pc_q <= '0;
				resolved_next_pc_q  <= '0;
				dir_match_q         <= 1'b0;
				npc_match_q         <= 1'b0;
				ideal_dir_match_q   <= 1'b0;
				ideal_npc_match_q   <= 1'b0;
				lookup_kind_q       <= sbp_pkg::LK_DISABLED;
				update_kind_q       <= sbp_pkg::UK_NONE;
				target_mismatch_q   <= 1'b0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign predict_taken     = predict_taken_q;
	assign predicted_next_pc = predicted_next_pc_q;
	assign resolved_next_pc  = resolved_next_pc_q;
	assign dir_match         = dir_match_q;
	assign npc_match         = npc_match_q;
	assign ideal_dir_match   = ideal_dir_match_q;
	assign ideal_npc_match   = ideal_npc_match_q;
	assign lookup_kind       = lookup_kind_q;
	assign update_kind       = update_kind_q;
	assign target_mismatch   = target_mismatch_q;

endmodule

[rtl/core/sbp_decode.sv]
// ----------------------------------------------------------------------------
// sbp_decode
// Checks a RISC-V branch encoding and works out its target and fall-through.
// ----------------------------------------------------------------------------
module sbp_decode (
	input  logic [31:0]        branch_pc,
	input  logic [31:0]        instruction_word,
	output sbp_pkg::dec_t      dec
);

	logic [12:0] imm;
	logic [2:0]  funct3;

	assign funct3 = instruction_word[14:12];
	assign imm = {instruction_word[31], instruction_word[7], instruction_word[30:25],
		instruction_word[11:8], 1'b0};

	always_comb begin
		if ((instruction_word[6:0] & sbp_pkg::OPCODE_MASK) != sbp_pkg::OPCODE_BRANCH) begin
			dec.status = sbp_pkg::ST_NOT_BRANCH;
		end else if (funct3 inside {sbp_pkg::FUNCT3_RSV_A, sbp_pkg::FUNCT3_RSV_B}) begin
			dec.status = sbp_pkg::ST_RSV_FUNCT3;
		end else begin
			dec.status = sbp_pkg::ST_VALID_BRANCH;
		end
		dec.backward = imm[12];
		// Sign extension of the 13-bit offset; the add wraps modulo 2^32.
		dec.target = branch_pc + {{19{imm[12]}}, imm};
		dec.seq    = branch_pc + sbp_pkg::PC_STEP;
	end

endmodule

[rtl/core/sbp_checker.sv]
// ----------------------------------------------------------------------------
// sbp_checker
// Port-level checks for the static branch predictor, bound to the top level.
// ----------------------------------------------------------------------------
module sbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic        predict_taken,
	input logic [31:0] predicted_next_pc,
	input logic [31:0] resolved_next_pc,
	input logic [1:0]  lookup_kind,
	input logic [1:0]  update_kind,
	input logic        target_mismatch
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(predicted_next_pc)
			&& $stable(resolved_next_pc) && $stable(status))
		else $error("stalled result changed");

	// A request that is not a usable branch never touches the BTB.
	a_bad_no_btb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != sbp_pkg::ST_VALID_BRANCH) |->
			(lookup_kind == sbp_pkg::LK_DISABLED) && (update_kind == sbp_pkg::UK_NONE)
			&& !predict_taken && !target_mismatch)
		else $error("invalid branch reported a BTB access");

	// The update kind follows from the lookup kind.
	a_kind_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			((lookup_kind == sbp_pkg::LK_HIT) && (update_kind == sbp_pkg::UK_REFRESH))
			|| ((lookup_kind == sbp_pkg::LK_COLD_MISS) && (update_kind == sbp_pkg::UK_COLD_FILL))
			|| ((lookup_kind == sbp_pkg::LK_CONFLICT) && (update_kind == sbp_pkg::UK_REPLACE))
			|| ((lookup_kind == sbp_pkg::LK_DISABLED) && (update_kind == sbp_pkg::UK_NONE)))
		else $error("lookup and update kinds disagree");

	// A target mismatch is only reported on a hit, and a miss predicts not taken.
	a_miss_fallthrough: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((lookup_kind == sbp_pkg::LK_COLD_MISS)
			|| (lookup_kind == sbp_pkg::LK_CONFLICT)) |->
			!predict_taken && !target_mismatch)
		else $error("miss predicted taken or reported a mismatch");

endmodule

bind static_branch_predictor_btb sbp_checker u_sbp_checker (.*);

[tb/sbp_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbp_result_checker
// Follows both channels of the branch predictor, works out each result from
// its own copy of the BTB and registers, and compares field by field.
// ----------------------------------------------------------------------------
module sbp_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] branch_pc,
	input  logic [31:0] instruction_word,
	input  logic        branch_taken,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic        predict_taken,
	input  logic [31:0] predicted_next_pc,
	input  logic [31:0] resolved_next_pc,
	input  logic        dir_match,
	input  logic        npc_match,
	input  logic        ideal_dir_match,
	input  logic        ideal_npc_match,
	input  logic [1:0]  lookup_kind,
	input  logic [1:0]  update_kind,
	input  logic        target_mismatch,
	output int          outstanding,
	output int          mismatches
);

	localparam int ENTRY_BITS = 3;
	localparam int ENTRIES    = 1 << ENTRY_BITS;

	typedef struct packed {
		logic [1:0]  status;
		logic        pred_taken;
		logic [31:0] pred_next;
		logic [31:0] resolved;
		logic        dir_ok;
		logic        next_ok;
		logic        ideal_dir_ok;
		logic        ideal_next_ok;
		logic [1:0]  lookup;
		logic [1:0]  update;
		logic        mismatch;
	} branch_verdict_t;

	logic [1:0]  policy;
	logic        btb_on;
	logic [1:0]  index_bits;
	logic        slot_valid [ENTRIES];
	logic [31:0] slot_pc [ENTRIES];
	logic [31:0] slot_target [ENTRIES];
	logic        slot_backward [ENTRIES];

	branch_verdict_t branch_verdicts [$];
	int fail_count = 0;
	int queued     = 0;

	assign outstanding = queued;
	assign mismatches  = fail_count;

	function automatic logic takes_branch(input logic [1:0] mode, input logic backward);
		case (mode)
			sbp_pkg::MODE_TAKEN: return 1'b1;
			sbp_pkg::MODE_BTFN:  return backward;
			default:             return 1'b0;
		endcase
	endfunction

	// Decodes one branch, looks it up and refreshes the BTB copy.
	function automatic branch_verdict_t predict_branch(input logic [31:0] pc,
			input logic [31:0] inst, input logic taken);
		branch_verdict_t v;
		logic [12:0] imm;
		logic        backward;
		logic        ideal_taken;
		logic [31:0] target;
		logic [31:0] seq;
		logic [31:0] ideal_next;
		int          bits;
		int          slot;
		v        = '0;
		v.lookup = sbp_pkg::LK_DISABLED;
		v.update = sbp_pkg::UK_NONE;
		if ((inst[6:0] & sbp_pkg::OPCODE_MASK) != sbp_pkg::OPCODE_BRANCH) begin
			v.status = sbp_pkg::ST_NOT_BRANCH;
			return v;
		end
		if (inst[14:12] == sbp_pkg::FUNCT3_RSV_A || inst[14:12] == sbp_pkg::FUNCT3_RSV_B) begin
			v.status = sbp_pkg::ST_RSV_FUNCT3;
			return v;
		end
		imm         = {inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
		backward    = imm[12];
		target      = pc + {{19{imm[12]}}, imm};
		seq         = pc + sbp_pkg::PC_STEP;
		ideal_taken = takes_branch(policy, backward);
		ideal_next  = ideal_taken ? target : seq;
		v.status     = sbp_pkg::ST_VALID_BRANCH;
		v.resolved   = taken ? target : seq;
		v.pred_taken = ideal_taken;
		v.pred_next  = ideal_next;
		if (btb_on) begin
			bits = (index_bits > ENTRY_BITS) ? ENTRY_BITS : index_bits;
			slot = int'((pc >> 2) & ((32'd1 << bits) - 32'd1));
			if (slot_valid[slot] && slot_pc[slot] == pc) begin
				v.lookup     = sbp_pkg::LK_HIT;
				v.update     = sbp_pkg::UK_REFRESH;
				v.mismatch   = (slot_target[slot] != target);
				v.pred_taken = takes_branch(policy, slot_backward[slot]);
				v.pred_next  = v.pred_taken ? slot_target[slot] : seq;
			end else begin
				v.lookup     = slot_valid[slot] ? sbp_pkg::LK_CONFLICT : sbp_pkg::LK_COLD_MISS;
				v.update     = slot_valid[slot] ? sbp_pkg::UK_REPLACE : sbp_pkg::UK_COLD_FILL;
				v.pred_taken = 1'b0;
				v.pred_next  = seq;
			end
			slot_valid[slot]    = 1'b1;
			slot_pc[slot]       = pc;
			slot_target[slot]   = target;
			slot_backward[slot] = backward;
		end
		v.dir_ok        = (v.pred_taken == taken);
		v.next_ok       = (v.pred_next == v.resolved);
		v.ideal_dir_ok  = (ideal_taken == taken);
		v.ideal_next_ok = (ideal_next == v.resolved);
		return v;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		branch_verdict_t want;
		if (!arst_n) begin
			policy     = sbp_pkg::MODE_BTFN;
			btb_on     = 1'b1;
			index_bits = 2'd3;
			for (int i = 0; i < ENTRIES; i++) begin
				slot_valid[i]    = 1'b0;
				slot_pc[i]       = '0;
				slot_target[i]   = '0;
				slot_backward[i] = 1'b0;
			end
			branch_verdicts.delete();
			queued <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sbp_pkg::REG_DIRECTION_MODE: policy     = cfg_data;
					sbp_pkg::REG_BTB_ENABLE:     btb_on     = cfg_data[0];
					sbp_pkg::REG_BTB_INDEX_BITS: index_bits = cfg_data;
					default: ;
				endcase
			end
			// A result accepted now belongs to an older request, so it is
			// matched before this edge's request is queued.
			if (out_valid && out_ready) begin
				if (branch_verdicts.size() == 0) begin
					$error("result accepted with no request outstanding");
					fail_count++;
				end else begin
					want = branch_verdicts.pop_front();
					check_field("status", want.status, status);
					check_field("predict_taken", want.pred_taken, predict_taken);
					check_field("predicted_next_pc", want.pred_next, predicted_next_pc);
					check_field("resolved_next_pc", want.resolved, resolved_next_pc);
					check_field("dir_match", want.dir_ok, dir_match);
					check_field("npc_match", want.next_ok, npc_match);
					check_field("ideal_dir_match", want.ideal_dir_ok, ideal_dir_match);
					check_field("ideal_npc_match", want.ideal_next_ok, ideal_npc_match);
					check_field("lookup_kind", want.lookup, lookup_kind);
					check_field("update_kind", want.update, update_kind);
					check_field("target_mismatch", want.mismatch, target_mismatch);
				end
			end
			if (in_valid && in_ready)
				branch_verdicts.push_back(predict_branch(branch_pc, instruction_word,
					branch_taken));
			queued <= branch_verdicts.size();
		end
	end

endmodule

[tb/tb_static_branch_predictor_btb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_static_branch_predictor_btb
// Drives traced branches into the BTB predictor under several direction
// policies, BTB sizes and with the BTB switched off, with random gaps on both
// channels, and lets the result checker judge every result.
// ----------------------------------------------------------------------------
module tb_static_branch_predictor_btb;

	// Generous bound on the whole run: roughly 1600 requests, each of which
	// may sit through long receiver stalls, plus the clearing pass after reset.
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 172;
	localparam int POOL_SIZE   = 12;
	localparam int LONG_STALL  = 80;

	// Conditional branch kinds by funct3.
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// The policy code left unused, which behaves as not taken.
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [1:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] branch_pc;
	logic [31:0] instruction_word;
	logic        branch_taken;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic        predict_taken;
	logic [31:0] predicted_next_pc;
	logic [31:0] resolved_next_pc;
	logic        dir_match;
	logic        npc_match;
	logic        ideal_dir_match;
	logic        ideal_npc_match;
	logic [1:0]  lookup_kind;
	logic [1:0]  update_kind;
	logic        target_mismatch;

	int outstanding;
	int mismatches;
	int cycles        = 0;
	int send_idle_pct = 14;
	int recv_idle_pct = 57;
	int stall_req     = 0;
	int stall_seen    = 0;
	int stall_left    = 0;

	// A small "program": a handful of branch sites with fixed encodings, so
	// that sites recur and the BTB sees hits, refreshes and conflicts.
	logic [31:0] prog_pc [POOL_SIZE];
	logic [31:0] prog_inst [POOL_SIZE];

	static_branch_predictor_btb #(.BTB_SLOTS(8)) DUT (.*);

	sbp_result_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver. It stalls at random, and whenever the main process asks for it
	// it holds off for a long stretch counted here, so that the block fills up
	// and pushes back on its input.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_req != stall_seen) begin
			out_ready  <= 1'b0;
			stall_seen <= stall_req;
			stall_left <= LONG_STALL;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Builds a B-type word; the register fields are random as they do not
	// matter to the predictor.
	function automatic logic [31:0] make_branch(input logic [2:0] funct3, input int offset);
		logic [12:0] imm;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		imm = offset[12:0];
		rs1 = 5'($urandom);
		rs2 = 5'($urandom);
		return {imm[12], imm[10:5], rs2, rs1, funct3, imm[4:1], imm[11],
			sbp_pkg::OPCODE_BRANCH};
	endfunction

	function automatic logic [2:0] valid_funct3();
		case ($urandom_range(5))
			0:       return F3_BEQ;
			1:       return F3_BNE;
			2:       return F3_BLT;
			3:       return F3_BGE;
			4:       return F3_BLTU;
			default: return F3_BGEU;
		endcase
	endfunction

	// Offers one request, idling first at the sender's current rate, and
	// returns at the edge where it is accepted.
	task automatic send_request(input logic [31:0] pc, input logic [31:0] inst,
			input logic taken);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		branch_pc        <= pc;
		instruction_word <= inst;
		branch_taken     <= taken;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stops offering and waits until every request has had its result.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes all three registers on consecutive edges; the block is idle here.
	task automatic apply_config(input logic [1:0] mode, input logic enable,
			input logic [1:0] bits);
		cfg_we    <= 1'b1;
		cfg_index <= sbp_pkg::REG_DIRECTION_MODE;
		cfg_data  <= mode;
		@(posedge clk);
		cfg_index <= sbp_pkg::REG_BTB_ENABLE;
		cfg_data  <= {1'b0, enable};
		@(posedge clk);
		cfg_index <= sbp_pkg::REG_BTB_INDEX_BITS;
		cfg_data  <= bits;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [31:0] base;
		int          pick;
		int          k;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = sbp_pkg::REG_DIRECTION_MODE;
		cfg_data         = '0;
		in_valid         = 1'b0;
		branch_pc        = '0;
		instruction_word = '0;
		branch_taken     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings: backward taken, forward not,
		// full eight-entry BTB. The clearing pass holds in_ready low meanwhile.
		send_request(32'h0000_1000, make_branch(F3_BEQ, -8), 1'b1);   // cold miss
		send_request(32'h0000_1000, make_branch(F3_BEQ, -8), 1'b1);   // hit, taken
		send_request(32'h0000_1000, make_branch(F3_BNE, 16), 1'b0);   // stale target
		send_request(32'h0000_1020, make_branch(F3_BLT, 16), 1'b1);   // same slot
		send_request(32'h0000_1004, 32'hFFFF_FFFF, 1'b1);             // not a branch
		send_request(32'h0000_1004, 32'h0000_0000, 1'b0);
		send_request(32'h0000_1008, make_branch(sbp_pkg::FUNCT3_RSV_A, 8), 1'b1);
		send_request(32'h0000_1008, make_branch(sbp_pkg::FUNCT3_RSV_B, 8), 1'b0);
		// Largest backward and forward offsets, with the pc wrapping both ways.
		send_request(32'h0000_0000, make_branch(F3_BGE, -4096), 1'b1);
		send_request(32'hFFFF_FFFC, make_branch(F3_BLTU, 4094), 1'b1);
		send_request(32'hFFFF_FFFC, make_branch(F3_BLTU, 4094), 1'b0);
		send_request(32'hFFFF_FFFF, make_branch(F3_BGE, 0), 1'b1);     // odd pc
		send_request(32'h0000_2000, make_branch(F3_BLTU, -2), 1'b0);
		send_request(32'h0000_2004, make_branch(F3_BGEU, 2), 1'b1);

		// A single-entry BTB: every distinct pc fights over slot zero.
		drain_results();
		apply_config(sbp_pkg::MODE_NOT_TAKEN, 1'b1, 2'd0);
		send_request(32'h0000_3000, make_branch(F3_BEQ, 8), 1'b1);
		send_request(32'h0000_3004, make_branch(F3_BNE, -12), 1'b1);
		send_request(32'h0000_3004, make_branch(F3_BNE, -12), 1'b0);

		// BTB switched off: the ideal path alone, entries kept untouched.
		drain_results();
		apply_config(sbp_pkg::MODE_TAKEN, 1'b0, 2'd3);
		send_request(32'h0000_1000, make_branch(F3_BNE, 16), 1'b1);
		send_request(32'h0000_1020, make_branch(F3_BLT, -8), 1'b0);

		// The unused policy code, which must behave as not taken.
		drain_results();
		apply_config(MODE_RESERVED, 1'b1, 2'd1);
		send_request(32'h0000_1000, make_branch(F3_BNE, 16), 1'b1);
		send_request(32'h0000_1000, make_branch(F3_BNE, 16), 1'b1);

		// Random part. Each phase has its own settings and program; the first
		// three idle the sender lightly and the receiver heavily, the next
		// three the other way round, and the last three run flat out.
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			case (p)
				0:       apply_config(sbp_pkg::MODE_BTFN, 1'b1, 2'd3);
				1:       apply_config(sbp_pkg::MODE_NOT_TAKEN, 1'b1, 2'd0);
				2:       apply_config(sbp_pkg::MODE_TAKEN, 1'b1, 2'd1);
				3:       apply_config(MODE_RESERVED, 1'b1, 2'd2);
				4:       apply_config(sbp_pkg::MODE_BTFN, 1'b0, 2'd3);
				5:       apply_config(sbp_pkg::MODE_TAKEN, 1'b0, 2'd0);
				6:       apply_config(sbp_pkg::MODE_BTFN, 1'b1, 2'd1);
				7:       apply_config(sbp_pkg::MODE_NOT_TAKEN, 1'b1, 2'd3);
				default: apply_config(sbp_pkg::MODE_TAKEN, 1'b1, 2'd3);
			endcase
			send_idle_pct = (p < 3) ? 14 : (p < 6) ? 57 : 0;
			recv_idle_pct <= (p < 3) ? 57 : (p < 6) ? 14 : 0;

			// Sites lie close together so that they share BTB slots.
			base = $urandom & 32'hFFFF_FFFC;
			for (int s = 0; s < POOL_SIZE; s++) begin
				prog_pc[s]   = base + 32'($urandom_range(31)) * 4;
				prog_inst[s] = make_branch(valid_funct3(), $urandom_range(8191));
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((p == 2 || p == 8) && n == 30)
					stall_req <= stall_req + 1;
				if (p == 4 && n == PHASE_ITEMS / 2)
					drain_results();
				pick = $urandom_range(99);
				if (pick < 84) begin
					// Mostly a known site; now and then its code changes under
					// it, so that a hit finds a stale target.
					k = $urandom_range(POOL_SIZE - 1);
					if ($urandom_range(99) < 6)
						prog_inst[k] = make_branch(valid_funct3(), $urandom_range(8191));
					send_request(prog_pc[k], prog_inst[k], 1'($urandom_range(1)));
				end else if (pick < 92) begin
					send_request($urandom, $urandom, 1'($urandom_range(1)));
				end else begin
					send_request($urandom, make_branch(3'($urandom_range(7)),
						$urandom_range(8191)), 1'($urandom_range(1)));
				end
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
